### rtl/sensor_frame_parser_thresholds_unit_macros.svh
// Assertion helpers for the RTL files; only sfpt_parser uses them.
`ifndef SENSOR_FRAME_PARSER_THRESHOLDS_UNIT_MACROS_SVH
`define SENSOR_FRAME_PARSER_THRESHOLDS_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i, muted while in reset.
`define SFPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, muted while in reset.
`define SFPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfpt_pkg.sv
package sfpt_pkg;

  localparam logic [7:0] SyncByte  = 8'h5A;
  localparam logic [7:0] TypeLight = 8'h15;
  localparam logic [7:0] TypeEnv   = 8'h45;
  localparam logic [7:0] LenLight  = 8'd4;
  localparam logic [7:0] LenEnv    = 8'd10;

  // only the longest known frame needs its bytes kept
  localparam int unsigned StoreDepth = 10;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);

  localparam int unsigned LuxW  = 26;
  localparam int unsigned TempW = 10;
  localparam int unsigned PresW = 16;
  localparam int unsigned HumW  = 10;
  localparam int unsigned AltW  = 16;

  localparam logic [LuxW-1:0]  LuxThrReset  = 26'd50;
  localparam logic [TempW-1:0] TempThrReset = 10'd30;

  // configuration register indexes
  localparam logic CfgIdxLux  = 1'b0;
  localparam logic CfgIdxTemp = 1'b1;

  localparam logic KindLight = 1'b0;
  localparam logic KindEnv   = 1'b1;

  // raw words of one complete frame
  typedef struct packed {
    logic        kind;
    logic [31:0] word;      // light value or pressure
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic [15:0] alt_raw;
  } frame_t;

  // scaled values of one frame
  typedef struct packed {
    logic             kind;
    logic [LuxW-1:0]  lux;
    logic [TempW-1:0] temperature;
    logic [PresW-1:0] pressure;
    logic [HumW-1:0]  humidity;
    logic [AltW-1:0]  altitude;
  } quot_t;

  // output item, last field in the low bits
  typedef struct packed {
    logic             beep_on;
    logic             lamp_on;
    logic [AltW-1:0]  altitude;
    logic [HumW-1:0]  humidity;
    logic [PresW-1:0] pressure;
    logic [TempW-1:0] temperature;
    logic [LuxW-1:0]  lux;
  } result_t;

  // x / 100 = (x >> 2) / 25, reciprocal 2^35 / 25 rounded up, exact for 30 bits
  function automatic logic [LuxW-1:0] div100_32(input logic [31:0] x);
    logic [60:0] p;
    p = 61'(x[31:2]) * 61'(31'd1374389535);
    return p[60:35];
  endfunction

  // x / 100 for 16-bit words, reciprocal 2^19 / 25 rounded up
  function automatic logic [TempW-1:0] div100_16(input logic [15:0] x);
    logic [28:0] p;
    p = 29'(x[15:2]) * 29'(15'd20972);
    return p[28:19];
  endfunction

  // x / 100000 = (x >> 5) / 3125, reciprocal 2^39 / 3125 rounded up
  function automatic logic [PresW-1:0] div100k_32(input logic [31:0] x);
    logic [54:0] p;
    p = 55'(x[31:5]) * 55'(28'd175921861);
    return p[54:39];
  endfunction

endpackage

### rtl/sensor_frame_parser_thresholds_unit.sv
// Sensor frame parser with lamp and beeper thresholds.
// Input stream: one received serial byte per item on s_axis. The parser hunts
// two 0x5A sync bytes, then takes type, length, payload and a checksum byte
// (not checked). A light frame (type 0x15, length 4) or an environment frame
// (type 0x45, length 10) yields one item on m_axis when its checksum byte is
// taken; all other frames, including payloads longer than ten bytes, yield none.
// Output: tuser is the frame kind, tdata carries the scaled values and the
// lamp and beeper drive after this frame (light below lux threshold turns the
// lamp on, temperature above temp threshold turns the beeper on).
// Throughput: one byte per cycle while s_axis_tready is high. Path: the frame
// register loads on the edge that takes the checksum byte, then the reciprocal
// multiply register, then the threshold/output register (m_axis_tvalid).
// Stall: each stage holds its item while the next is full; s_axis_tready drops
// only when a finished frame cannot move on, so bytes are never lost.
// Config: cfg channel is always ready; write only while no frame is in flight.
// Reset: parser hunts the first sync byte, lamp and beeper off, thresholds at
// 50 lux and 30 degrees, all pipeline stages empty.
module sensor_frame_parser_thresholds_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // lux[25:0] temperature[35:26] pressure[51:36] humidity[61:52]
  // altitude[77:62] lamp_on[78] beep_on[79]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,   // frame_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,     // 0 lux_threshold, 1 temp_threshold
  input  logic [25:0] cfg_data_i
);

  logic [sfpt_pkg::LuxW-1:0]  lux_thr_q;
  logic [sfpt_pkg::TempW-1:0] temp_thr_q;

  logic              frm_valid, frm_ready;
  sfpt_pkg::frame_t  frm;
  logic              quot_valid, quot_ready;
  sfpt_pkg::quot_t   quot;
  sfpt_pkg::result_t res;

  // threshold registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lux_thr_q  <= sfpt_pkg::LuxThrReset;
      temp_thr_q <= sfpt_pkg::TempThrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        sfpt_pkg::CfgIdxLux:  lux_thr_q  <= cfg_data_i;
        sfpt_pkg::CfgIdxTemp: temp_thr_q <= cfg_data_i[sfpt_pkg::TempW-1:0];
        default: ;
      endcase
    end
  end

  // byte parser and frame register
  sfpt_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .frm_valid_o  (frm_valid),
    .frm_ready_i  (frm_ready),
    .frm_o        (frm)
  );

  // constant-divisor scaling
  sfpt_divide u_divide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frm_valid_i  (frm_valid),
    .frm_ready_o  (frm_ready),
    .frm_i        (frm),
    .quot_valid_o (quot_valid),
    .quot_ready_i (quot_ready),
    .quot_o       (quot)
  );

  // threshold compare, lamp/beeper state, output register
  sfpt_decide u_decide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .quot_valid_i (quot_valid),
    .quot_ready_o (quot_ready),
    .quot_i       (quot),
    .lux_thr_i    (lux_thr_q),
    .temp_thr_i   (temp_thr_q),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_kind_o   (m_axis_tuser),
    .res_o        (res)
  );

  assign m_axis_tdata = res;

endmodule

### rtl/sfpt_parser.sv
module sfpt_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_valid_i,
  output logic                byte_ready_o,
  input  logic [7:0]          byte_i,
  output logic                frm_valid_o,
  input  logic                frm_ready_i,
  output sfpt_pkg::frame_t    frm_o
);

  `include "sensor_frame_parser_thresholds_unit_macros.svh"

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       type_q, type_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             frm_valid_q;
  sfpt_pkg::frame_t frm_q, frm_d;
  logic [7:0]       store_q [sfpt_pkg::StoreDepth];
  logic             in_acc, frm_load, store_we, is_light, is_env;

  assign byte_ready_o = !frm_valid_q || frm_ready_i;
  assign in_acc       = byte_valid_i && byte_ready_o;
  assign is_light     = (type_q == sfpt_pkg::TypeLight) && (len_q == sfpt_pkg::LenLight);
  assign is_env       = (type_q == sfpt_pkg::TypeEnv) && (len_q == sfpt_pkg::LenEnv);
  assign store_we     = in_acc && (phase_q == PH_DATA)
                        && (cnt_q < 8'(sfpt_pkg::StoreDepth));

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    frm_load = 1'b0;
    if (in_acc) begin
      unique case (phase_q)
        PH_SYNC2: phase_d = (byte_i == sfpt_pkg::SyncByte) ? PH_TYPE : PH_SYNC1;
        PH_TYPE: begin
          type_d  = byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          len_d   = byte_i;
          cnt_d   = 8'd0;
          phase_d = (byte_i == 8'd0) ? PH_CSUM : PH_DATA;
        end
        PH_DATA: begin
          cnt_d = cnt_q + 8'd1;
          if (cnt_d >= len_q) begin
            phase_d = PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase_d  = PH_SYNC1;
          frm_load = is_light || is_env;   // long payloads never match
        end
        default: phase_d = (byte_i == sfpt_pkg::SyncByte) ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  always_comb begin
    frm_d.kind     = is_env ? sfpt_pkg::KindEnv : sfpt_pkg::KindLight;
    frm_d.word     = is_env ? {store_q[2], store_q[3], store_q[4], store_q[5]}
                            : {store_q[0], store_q[1], store_q[2], store_q[3]};
    frm_d.temp_raw = {store_q[0], store_q[1]};
    frm_d.hum_raw  = {store_q[6], store_q[7]};
    frm_d.alt_raw  = {store_q[8], store_q[9]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      type_q      <= 8'd0;
      len_q       <= 8'd0;
      cnt_q       <= 8'd0;
      frm_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      if (byte_ready_o) begin
        frm_valid_q <= frm_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_load) begin
      frm_q <= frm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cnt_q[sfpt_pkg::StoreIdxW-1:0]] <= byte_i;
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

  `SFPT_ASSERT_IMP(a_load_at_csum, frm_load, phase_q == PH_CSUM,
    "frame issued outside the checksum byte")
  `SFPT_ASSERT_IMP(a_cnt_below_len, phase_q == PH_DATA, cnt_q < len_q,
    "payload count reached length while still taking payload")
  `SFPT_ASSERT_NXT(a_bad_sync2,
    in_acc && (phase_q == PH_SYNC2) && (byte_i != sfpt_pkg::SyncByte),
    phase_q == PH_SYNC1, "bad second sync did not restart the hunt")
  `SFPT_ASSERT_NXT(a_frame_held, frm_valid_q && !frm_ready_i,
    frm_valid_q && $stable(frm_q), "stalled frame lost or changed")

endmodule

### rtl/sfpt_divide.sv
module sfpt_divide (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             frm_valid_i,
  output logic             frm_ready_o,
  input  sfpt_pkg::frame_t frm_i,
  output logic             quot_valid_o,
  input  logic             quot_ready_i,
  output sfpt_pkg::quot_t  quot_o
);

  logic            valid_q;
  sfpt_pkg::quot_t quot_q, quot_d;
  logic            env;

  assign frm_ready_o = !valid_q || quot_ready_i;
  assign env         = (frm_i.kind == sfpt_pkg::KindEnv);

  // constant divisors as reciprocal multiplies; unused fields read zero
  always_comb begin
    quot_d.kind        = frm_i.kind;
    quot_d.lux         = env ? '0 : sfpt_pkg::div100_32(frm_i.word);
    quot_d.temperature = env ? sfpt_pkg::div100_16(frm_i.temp_raw) : '0;
    quot_d.pressure    = env ? sfpt_pkg::div100k_32(frm_i.word) : '0;
    quot_d.humidity    = env ? sfpt_pkg::div100_16(frm_i.hum_raw) : '0;
    quot_d.altitude    = env ? frm_i.alt_raw : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frm_ready_o) begin
      valid_q <= frm_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frm_ready_o && frm_valid_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_valid_o = valid_q;
  assign quot_o       = quot_q;

endmodule

### rtl/sfpt_decide.sv
module sfpt_decide (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              quot_valid_i,
  output logic                              quot_ready_o,
  input  sfpt_pkg::quot_t                   quot_i,
  input  logic [sfpt_pkg::LuxW-1:0]         lux_thr_i,
  input  logic [sfpt_pkg::TempW-1:0]        temp_thr_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic                              res_kind_o,
  output sfpt_pkg::result_t                 res_o
);

  logic              valid_q;
  logic              lamp_q, lamp_d, beep_q, beep_d;
  logic              kind_q;
  sfpt_pkg::result_t res_q, res_d;
  logic              acc;

  assign quot_ready_o = !valid_q || res_ready_i;
  assign acc          = quot_valid_i && quot_ready_o;

  always_comb begin
    lamp_d = lamp_q;
    beep_d = beep_q;
    if (quot_i.kind == sfpt_pkg::KindEnv) begin
      beep_d = quot_i.temperature > temp_thr_i;
    end else begin
      lamp_d = quot_i.lux < lux_thr_i;
    end
    res_d.lux         = quot_i.lux;
    res_d.temperature = quot_i.temperature;
    res_d.pressure    = quot_i.pressure;
    res_d.humidity    = quot_i.humidity;
    res_d.altitude    = quot_i.altitude;
    res_d.lamp_on     = lamp_d;
    res_d.beep_on     = beep_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lamp_q  <= 1'b0;
      beep_q  <= 1'b0;
    end else begin
      if (quot_ready_o) begin
        valid_q <= quot_valid_i;
      end
      if (acc) begin
        lamp_q <= lamp_d;
        beep_q <= beep_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q  <= res_d;
      kind_q <= quot_i.kind;
    end
  end

  assign res_valid_o = valid_q;
  assign res_kind_o  = kind_q;
  assign res_o       = res_q;

endmodule
